/* sv/m2m4_pkg.sv */
// ----------------------------------------------------------------------------
// m2m4 estimator package
// widths, item types and the step table of the shared multiply-accumulate
// ----------------------------------------------------------------------------
package m2m4_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int MAG_W       = 12;
    localparam int ALPHA_W     = 16;
    localparam int BETA_W      = 17;
    localparam int FRAC_BITS   = 16;
    localparam int POW_W       = 24;
    localparam int P2_W        = 48;
    localparam int M2_W        = 40;
    localparam int M4_W        = 62;
    localparam int OPND_W      = 24;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int ACC_W       = 80;
    localparam int SQ2_W       = 63;
    localparam int RAD_W       = 48;
    localparam int SIG_W       = 24;
    localparam int NOISE_W     = 25;
    localparam int REM_W       = 26;
    localparam int SQRT_STEPS  = 24;
    localparam int SQRT_CNT_W  = 5;
    localparam int MAC_STEPS   = 15;
    localparam int STEP_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd66;

    typedef struct packed {
        logic [MAG_W-1:0] mag_i;
        logic [MAG_W-1:0] mag_q;
        logic             last;
    } q_entry_t;

    typedef enum logic [2:0] {
        OPA_MAG_I,
        OPA_MAG_Q,
        OPA_P,
        OPA_BETA,
        OPA_ALPHA,
        OPA_M2_LO,
        OPA_M2_HI
    } opa_t;

    typedef enum logic [3:0] {
        OPB_MAG_I,
        OPB_MAG_Q,
        OPB_P,
        OPB_M2_LO,
        OPB_M2_HI,
        OPB_M4_0,
        OPB_M4_1,
        OPB_M4_2,
        OPB_P2_LO,
        OPB_P2_HI
    } opb_t;

    typedef enum logic [2:0] {
        SH_0,
        SH_16,
        SH_24,
        SH_40,
        SH_48
    } shift_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_P,
        WR_P2,
        WR_M2,
        WR_M4
    } wsel_t;

    typedef struct packed {
        opa_t   opa;
        opb_t   opb;
        shift_t sh;
        logic   clr;
        wsel_t  wsel;
    } mac_ctrl_t;

    // power, fourth moment, both averages, then the square of the new m2
    function automatic mac_ctrl_t mac_step(input logic [STEP_W-1:0] step);
        mac_ctrl_t c;
        case (step)
            4'd0:  c = '{OPA_MAG_I, OPB_MAG_I, SH_0,  1'b1, WR_NONE};
            4'd1:  c = '{OPA_MAG_Q, OPB_MAG_Q, SH_0,  1'b0, WR_P};
            4'd2:  c = '{OPA_P,     OPB_P,     SH_0,  1'b1, WR_P2};
            4'd3:  c = '{OPA_BETA,  OPB_M2_LO, SH_0,  1'b1, WR_NONE};
            4'd4:  c = '{OPA_BETA,  OPB_M2_HI, SH_24, 1'b0, WR_NONE};
            4'd5:  c = '{OPA_ALPHA, OPB_P,     SH_16, 1'b0, WR_M2};
            4'd6:  c = '{OPA_BETA,  OPB_M4_0,  SH_0,  1'b1, WR_NONE};
            4'd7:  c = '{OPA_BETA,  OPB_M4_1,  SH_24, 1'b0, WR_NONE};
            4'd8:  c = '{OPA_BETA,  OPB_M4_2,  SH_48, 1'b0, WR_NONE};
            4'd9:  c = '{OPA_ALPHA, OPB_P2_LO, SH_16, 1'b0, WR_NONE};
            4'd10: c = '{OPA_ALPHA, OPB_P2_HI, SH_40, 1'b0, WR_M4};
            4'd11: c = '{OPA_M2_LO, OPB_M2_LO, SH_0,  1'b1, WR_NONE};
            4'd12: c = '{OPA_M2_LO, OPB_M2_HI, SH_24, 1'b0, WR_NONE};
            4'd13: c = '{OPA_M2_HI, OPB_M2_LO, SH_24, 1'b0, WR_NONE};
            4'd14: c = '{OPA_M2_HI, OPB_M2_HI, SH_48, 1'b0, WR_NONE};
            default: c = '{OPA_MAG_I, OPB_MAG_I, SH_0, 1'b1, WR_NONE};
        endcase
        return c;
    endfunction

endpackage

/* sv/m2m4_front.sv */
// ----------------------------------------------------------------------------
// m2m4 front end
// accepts sample items, takes the magnitudes of I and Q, feeds the queue
// ----------------------------------------------------------------------------
module m2m4_front import m2m4_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_i,
    input  logic signed [SAMPLE_W-1:0] s_sample_q,
    input  logic                       s_block_last,
    output logic                       q_valid,
    input  logic                       q_ready,
    output q_entry_t                   q_data
);

    logic     fe_valid_reg;
    logic     fe_valid_next;
    q_entry_t fe_data_reg;
    q_entry_t fe_data_next;
    logic     accept;

    assign s_ready = !fe_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_valid = fe_valid_reg;
    assign q_data  = fe_data_reg;

    always_comb begin
        fe_data_next.mag_i = s_sample_i[SAMPLE_W-1] ? MAG_W'(~s_sample_i + 1'b1)
                                                    : MAG_W'(s_sample_i);
        fe_data_next.mag_q = s_sample_q[SAMPLE_W-1] ? MAG_W'(~s_sample_q + 1'b1)
                                                    : MAG_W'(s_sample_q);
        fe_data_next.last  = s_block_last;
        if (accept) begin
            fe_valid_next = 1'b1;
        end else if (q_ready) begin
            fe_valid_next = 1'b0;
        end else begin
            fe_valid_next = fe_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fe_valid_reg <= 1'b0;
        end else begin
            fe_valid_reg <= fe_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fe_data_reg <= fe_data_next;
        end
    end

endmodule

/* sv/m2m4_fifo.sv */
// ----------------------------------------------------------------------------
// m2m4 item queue
// two-entry queue between the front end and the arithmetic core
// ----------------------------------------------------------------------------
module m2m4_fifo import m2m4_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  q_entry_t in_data,
    output logic     out_valid,
    input  logic     out_pop,
    output q_entry_t out_data
);

    q_entry_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule

/* sv/m2m4_isqrt.sv */
// ----------------------------------------------------------------------------
// m2m4 integer square root
// floor square root of a 48-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module m2m4_isqrt import m2m4_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [RAD_W-1:0] radicand,
    output logic             busy,
    output logic [SIG_W-1:0] root
);

    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [SIG_W-1:0]      root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      rem_sub;
    logic                  ge;

    assign busy = busy_reg;
    assign root = root_reg;

    always_comb begin
        rem_sh  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[SIG_W-2:0], ge};
        end
    end

endmodule

/* sv/m2m4_core.sv */
// ----------------------------------------------------------------------------
// m2m4 arithmetic core
// moving averages of power and fourth moment on a shared 24x24 multiply-
// accumulate, then the m2m4 signal and noise estimate
// ----------------------------------------------------------------------------
module m2m4_core import m2m4_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ALPHA_W-1:0]        cfg_alpha_q16,
    input  logic                      q_valid,
    input  q_entry_t                  q_data,
    output logic                      q_pop,
    output logic                      sq_start,
    output logic [RAD_W-1:0]          sq_radicand,
    input  logic                      sq_busy,
    input  logic [SIG_W-1:0]          sq_root,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SIG_W-1:0]          m_signal_power,
    output logic signed [NOISE_W-1:0] m_noise_power,
    output logic                      m_block_last_res
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_DIFF = 4'b0100,
        ST_SQRT = 4'b1000
    } core_state_t;

    core_state_t          state_reg;
    core_state_t          state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [BETA_W-1:0]    beta;
    logic [M2_W-1:0]      m2_reg;
    logic [M4_W-1:0]      m4_reg;
    logic [POW_W-1:0]     p_reg;
    logic [P2_W-1:0]      p2_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    q_entry_t             item_reg;
    mac_ctrl_t            ctrl;
    logic [OPND_W-1:0]    a_op;
    logic [OPND_W-1:0]    b_op;
    logic [PROD_W-1:0]    prod;
    logic [ACC_W-1:0]     prod_sh;
    logic [SQ2_W-1:0]     sq2;
    logic [SQ2_W-1:0]     sq2_diff;
    logic                 m_valid_reg;
    logic [SIG_W-1:0]     signal_reg;
    logic [NOISE_W-1:0]   noise_reg;
    logic                 last_res_reg;
    logic                 out_load;
    logic                 mac_run;

    assign cfg_ready        = 1'b1;
    assign beta             = BETA_W'(1) << ALPHA_W;
    assign m_valid          = m_valid_reg;
    assign m_signal_power   = signal_reg;
    assign m_noise_power    = $signed(noise_reg);
    assign m_block_last_res = last_res_reg;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign mac_run  = state_reg == ST_MAC;
    assign out_load = (state_reg == ST_SQRT) && !sq_busy && (!m_valid_reg || m_ready);
    assign sq_start = state_reg == ST_DIFF;

    // operand select and multiply-accumulate
    always_comb begin
        ctrl = mac_step(step_reg);
        case (ctrl.opa)
            OPA_MAG_I: a_op = OPND_W'(item_reg.mag_i);
            OPA_MAG_Q: a_op = OPND_W'(item_reg.mag_q);
            OPA_P:     a_op = p_reg;
            OPA_BETA:  a_op = OPND_W'(beta - BETA_W'(alpha_reg));
            OPA_ALPHA: a_op = OPND_W'(alpha_reg);
            OPA_M2_LO: a_op = m2_reg[OPND_W-1:0];
            OPA_M2_HI: a_op = OPND_W'(m2_reg[M2_W-1:OPND_W]);
            default:   a_op = '0;
        endcase
        case (ctrl.opb)
            OPB_MAG_I: b_op = OPND_W'(item_reg.mag_i);
            OPB_MAG_Q: b_op = OPND_W'(item_reg.mag_q);
            OPB_P:     b_op = p_reg;
            OPB_M2_LO: b_op = m2_reg[OPND_W-1:0];
            OPB_M2_HI: b_op = OPND_W'(m2_reg[M2_W-1:OPND_W]);
            OPB_M4_0:  b_op = m4_reg[OPND_W-1:0];
            OPB_M4_1:  b_op = m4_reg[2*OPND_W-1:OPND_W];
            OPB_M4_2:  b_op = OPND_W'(m4_reg[M4_W-1:2*OPND_W]);
            OPB_P2_LO: b_op = p2_reg[OPND_W-1:0];
            OPB_P2_HI: b_op = p2_reg[P2_W-1:OPND_W];
            default:   b_op = '0;
        endcase
        prod = a_op * b_op;
        case (ctrl.sh)
            SH_0:    prod_sh = ACC_W'(prod);
            SH_16:   prod_sh = ACC_W'(prod) << 16;
            SH_24:   prod_sh = ACC_W'(prod) << 24;
            SH_40:   prod_sh = ACC_W'(prod) << 40;
            SH_48:   prod_sh = ACC_W'(prod) << 48;
            default: prod_sh = ACC_W'(prod);
        endcase
        acc_next = (ctrl.clr ? '0 : acc_reg) + prod_sh;
    end

    // 2*m2^2 scaled down, less m4, scaled down again
    always_comb begin
        sq2      = acc_reg[2*M2_W-3:FRAC_BITS-1];
        sq2_diff = sq2 - SQ2_W'(m4_reg);
        if (sq2 > SQ2_W'(m4_reg)) begin
            sq_radicand = RAD_W'(sq2_diff[SQ2_W-1:FRAC_BITS]);
        end else begin
            sq_radicand = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (q_valid) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAC_STEPS - 1)) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            alpha_reg   <= ALPHA_RESET;
            m2_reg      <= '0;
            m4_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid) begin
                alpha_reg <= cfg_alpha_q16;
            end
            if (mac_run && ctrl.wsel == WR_M2) begin
                m2_reg <= acc_next[M2_W+FRAC_BITS-1:FRAC_BITS];
            end
            if (mac_run && ctrl.wsel == WR_M4) begin
                m4_reg <= acc_next[M4_W+FRAC_BITS-1:FRAC_BITS];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_data;
        end
        if (mac_run) begin
            acc_reg <= acc_next;
        end
        if (mac_run && ctrl.wsel == WR_P) begin
            p_reg <= acc_next[POW_W-1:0];
        end
        if (mac_run && ctrl.wsel == WR_P2) begin
            p2_reg <= acc_next[P2_W-1:0];
        end
        if (out_load) begin
            signal_reg   <= sq_root;
            noise_reg    <= {1'b0, m2_reg[M2_W-1:FRAC_BITS]} - {1'b0, sq_root};
            last_res_reg <= item_reg.last;
        end
    end

    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_start |-> !sq_busy)
        else $error("root unit started while busy");

    a_diff_to_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIFF |=> state_reg == ST_SQRT && sq_busy)
        else $error("root unit did not start after the difference");

    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> state_reg == ST_IDLE && m_valid_reg)
        else $error("result load did not finish the item");

    a_avg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_MAC |=> $stable(m2_reg) && $stable(m4_reg))
        else $error("averages changed outside the accumulate phase");

endmodule

/* sv/m2m4_snr_estimator_top.sv */
// ----------------------------------------------------------------------------
// m2m4 snr estimator, top level
// one result per complex sample: m2m4 signal power and signed noise power
// ----------------------------------------------------------------------------
// items: the core takes the next item from the queue only after 15 passes
//   through the shared 24x24 multiply-accumulate and the bit-serial square root
// reset: synchronous, active low; averages cleared, alpha back to 66,
//   queue and result register emptied
// ----------------------------------------------------------------------------
module m2m4_snr_estimator_top import m2m4_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ALPHA_W-1:0]        cfg_alpha_q16,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_i,
    input  logic signed [SAMPLE_W-1:0] s_sample_q,
    input  logic                      s_block_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SIG_W-1:0]          m_signal_power,
    output logic signed [NOISE_W-1:0] m_noise_power,
    output logic                      m_block_last_res
);

    logic             fe_valid;
    logic             fe_ready;
    q_entry_t         fe_data;
    logic             q_valid;
    logic             q_pop;
    q_entry_t         q_data;
    logic             sq_start;
    logic [RAD_W-1:0] sq_radicand;
    logic             sq_busy;
    logic [SIG_W-1:0] sq_root;

    m2m4_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_i   (s_sample_i),
        .s_sample_q   (s_sample_q),
        .s_block_last (s_block_last),
        .q_valid      (fe_valid),
        .q_ready      (fe_ready),
        .q_data       (fe_data)
    );

    m2m4_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (fe_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    m2m4_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_radicand),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    m2m4_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_alpha_q16    (cfg_alpha_q16),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .sq_start         (sq_start),
        .sq_radicand      (sq_radicand),
        .sq_busy          (sq_busy),
        .sq_root          (sq_root),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_signal_power   (m_signal_power),
        .m_noise_power    (m_noise_power),
        .m_block_last_res (m_block_last_res)
    );

endmodule

/* bench/m2m4_snr_estimator_top_tb.sv */
// ----------------------------------------------------------------------------
// m2m4 snr estimator testbench
// drives complex samples through the valid/ready input channel and
// checks every signal and noise power result against a fixed-point
// estimate kept in a scoreboard; alpha is rewritten between phases,
// and both channels idle in random bursts and one long receiver stall
// ----------------------------------------------------------------------------
module m2m4_snr_estimator_top_tb import m2m4_pkg::*; ();

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 120;
    localparam int NUM_PHASES = 8;

    typedef struct {
        bit [SIG_W-1:0]   sig;
        bit [NOISE_W-1:0] noise;
        bit               last;
    } power_result_t;

    class power_scoreboard;
        bit [ALPHA_W-1:0] alpha;
        bit [63:0] m2;
        bit [63:0] m4;
        power_result_t expected_powers[$];
        int checked;
        int mismatches;

        function new();
            alpha = ALPHA_RESET;
            m2 = '0;
            m4 = '0;
            checked = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction

        function bit [63:0] ema(bit [63:0] avg, bit [63:0] x);
            bit [127:0] acc;
            bit [ALPHA_W:0] beta;
            beta = 17'h10000 - {1'b0, alpha};
            acc = (128'(alpha) * 128'(x)) << FRAC_BITS;
            acc = acc + 128'(beta) * 128'(avg);
            acc = acc >> ALPHA_W;
            // saturate at 64 bits
            return (acc[127:64] != '0) ? '1 : acc[63:0];
        endfunction

        function bit [63:0] int_root(bit [63:0] x);
            bit [31:0] r;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                bit [31:0] c;
                c = r | (32'd1 << b);
                if ({32'd0, c} * {32'd0, c} <= x) r = c;
            end
            return {32'd0, r};
        endfunction

        function void note_sample(bit signed [SAMPLE_W-1:0] i, bit signed [SAMPLE_W-1:0] q,
                                  bit last);
            longint si;
            longint sq;
            bit [63:0] pwr;
            bit [63:0] pwr2;
            bit [127:0] sq2;
            bit [63:0] root_v;
            bit [63:0] diff;
            power_result_t r;
            si = i;
            sq = q;
            pwr = si * si + sq * sq;
            pwr2 = pwr * pwr;
            m2 = ema(m2, pwr);
            m4 = ema(m4, pwr2);
            sq2 = ((128'(m2) * 128'(m2)) << 1) >> FRAC_BITS;
            root_v = '0;
            if (sq2 > 128'(m4)) begin
                sq2 = (sq2 - 128'(m4)) >> FRAC_BITS;
                root_v = int_root((sq2[127:64] != '0) ? '1 : sq2[63:0]);
            end
            if (root_v > 64'hFF_FFFF) root_v = 64'hFF_FFFF;
            diff = (m2 >> FRAC_BITS) - root_v;
            r.sig = root_v[SIG_W-1:0];
            r.noise = diff[NOISE_W-1:0];
            r.last = last;
            expected_powers.push_back(r);
        endfunction

        function void check_result(logic [SIG_W-1:0] sig, logic [NOISE_W-1:0] noise,
                                   logic last);
            power_result_t e;
            if (expected_powers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: sig %0d noise %0d last %0b",
                             sig, $signed(noise), last);
                return;
            end
            e = expected_powers.pop_front();
            checked++;
            if (sig !== e.sig || noise !== e.noise || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at item %0d: exp sig %0d noise %0d last %0b",
                             checked, e.sig, $signed(e.noise), e.last);
                    $display("    got sig %0d noise %0d last %0b",
                             sig, $signed(noise), last);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ALPHA_W-1:0] cfg_alpha_q16 = ALPHA_RESET;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_i = '0;
    logic signed [SAMPLE_W-1:0] s_sample_q = '0;
    logic s_block_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SIG_W-1:0] m_signal_power;
    logic signed [NOISE_W-1:0] m_noise_power;
    logic m_block_last_res;

    power_scoreboard sb;
    int idle_pct = 0;
    int recv_pct = 0;
    bit long_hold_req = 1'b0;
    int items_sent = 0;
    int alpha_writes = 0;
    int unsigned cycles = 0;

    m2m4_snr_estimator_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_alpha_q16   (cfg_alpha_q16),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_i      (s_sample_i),
        .s_sample_q      (s_sample_q),
        .s_block_last    (s_block_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_signal_power  (m_signal_power),
        .m_noise_power   (m_noise_power),
        .m_block_last_res(m_block_last_res)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items pending", cycles, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int clamp12(int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    task automatic send_sample(input int si, input int sq, input bit last);
        int n;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            n = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_i <= si[SAMPLE_W-1:0];
        s_sample_q <= sq[SAMPLE_W-1:0];
        s_block_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(si[SAMPLE_W-1:0], sq[SAMPLE_W-1:0], last);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_alpha(input bit [ALPHA_W-1:0] a);
        drain();
        cfg_valid <= 1'b1;
        cfg_alpha_q16 <= a;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.alpha = a;
        alpha_writes++;
    endtask

    // constellation point of amplitude amp with noise, or a fully random sample
    task automatic pick_sample(input int amp, input int nz, output int si, output int sq);
        if ($urandom_range(0, 3) == 0) begin
            si = $urandom_range(0, 4095) - 2048;
            sq = $urandom_range(0, 4095) - 2048;
        end else begin
            si = ($urandom_range(0, 1) ? amp : -amp) + $urandom_range(0, 2 * nz) - nz;
            sq = ($urandom_range(0, 1) ? amp : -amp) + $urandom_range(0, 2 * nz) - nz;
            si = clamp12(si);
            sq = clamp12(sq);
        end
    endtask

    // result side: check accepted items, random ready bursts, one long stall
    initial begin : receiver
        int hold;
        hold = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_valid && m_ready)
                sb.check_result(m_signal_power, m_noise_power, m_block_last_res);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (recv_pct != 0 && $urandom_range(1, 100) <= recv_pct) begin
                m_ready <= 1'b0;
                hold = $urandom_range(1, 17) - 1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        int phase_alpha[NUM_PHASES] = '{1, 65535, -1, 4096, -1, 40000, -1, 66};
        int phase_idle[NUM_PHASES] = '{20, 40, 0, 25, 10, 30, 15, 0};
        int phase_recv[NUM_PHASES] = '{25, 10, 35, 0, 20, 40, 15, 0};
        int si;
        int sq;
        int amp;
        int nz;
        int a;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of alpha
        idle_pct = 10;
        recv_pct = 10;
        send_sample(2047, 2047, 1'b0);
        send_sample(-2048, -2048, 1'b1);
        send_sample(0, 0, 1'b0);
        send_sample(-1, 1, 1'b1);

        // full weight, extreme samples
        write_alpha(16'hFFFF);
        send_sample(-2048, -2048, 1'b0);
        send_sample(2047, 2047, 1'b1);
        send_sample(-2048, 2047, 1'b0);
        send_sample(2047, -2048, 1'b0);
        send_sample(0, 0, 1'b1);
        send_sample(1, 0, 1'b0);
        send_sample(0, -1, 1'b0);
        send_sample(-2048, 0, 1'b1);
        send_sample(1000, -1000, 1'b0);

        // zero weight holds both averages
        write_alpha(16'h0000);
        send_sample(2047, 2047, 1'b0);
        send_sample(-2048, 0, 1'b1);
        send_sample(5, -7, 1'b0);

        // smallest nonzero weight
        write_alpha(16'h0001);
        send_sample(-2048, -2048, 1'b1);
        send_sample(2047, -2048, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            a = (phase_alpha[ph] < 0) ? $urandom_range(1, 65535) : phase_alpha[ph];
            write_alpha(a[ALPHA_W-1:0]);
            idle_pct = phase_idle[ph];
            recv_pct = phase_recv[ph];
            amp = $urandom_range(1, 2047);
            nz = $urandom_range(0, 200);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 30) long_hold_req = 1'b1;
                // stretches with no idling inside a phase
                if (ph != NUM_PHASES - 1 && k % 40 == 20) begin
                    idle_pct = 0;
                    recv_pct = 0;
                end else if (ph != NUM_PHASES - 1 && k % 40 == 30) begin
                    idle_pct = phase_idle[ph];
                    recv_pct = phase_recv[ph];
                end
                pick_sample(amp, nz, si, sq);
                send_sample(si, sq, $urandom_range(0, 7) == 0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) sb.mismatches++;

        $display("ran %0d samples over %0d alpha writes, incl. zero and full weight",
                 items_sent, alpha_writes);
        $display("%0d results checked, %0d mismatches, one long receiver stall",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
